@@ rtl/atam_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atam_pkg: shared types and constants
// Types, CORDIC arctangent table and sequencer states for the tilt monitor.
// ----------------------------------------------------------------------------
package atam_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ANGLE_W = 17;
  localparam logic signed [16:0] ANGLE_MAX = 17'sd11520;
  localparam logic [1:0] REG_PITCH_ZERO = 2'd0;
  localparam logic [1:0] REG_ROLL_ZERO  = 2'd1;
  localparam logic [1:0] REG_TILT_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_NEXT,
    ST_RING_RD,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {A_IDLE, A_SQ, A_ROOT, A_ROT} aphase_t;

  // Arctangent of 2^-i in units of 1/32768 degree.
  function automatic logic [20:0] atan_step(input logic [3:0] i);
    logic [20:0] v;
    unique case (i)
      4'd0:  v = 21'd1474560;
      4'd1:  v = 21'd870484;
      4'd2:  v = 21'd459940;
      4'd3:  v = 21'd233473;
      4'd4:  v = 21'd117189;
      4'd5:  v = 21'd58652;
      4'd6:  v = 21'd29333;
      4'd7:  v = 21'd14667;
      4'd8:  v = 21'd7334;
      4'd9:  v = 21'd3667;
      4'd10: v = 21'd1833;
      4'd11: v = 21'd917;
      4'd12: v = 21'd458;
      4'd13: v = 21'd229;
      4'd14: v = 21'd115;
      default: v = 21'd57;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/atam_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atam_in_if / atam_out_if: request channels
// Valid/ready channels carrying one accelerometer sample or one result.
// ----------------------------------------------------------------------------
interface atam_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atam_out_if;
  logic valid;
  logic ready;
  logic signed [16:0] mean_pitch;
  logic signed [16:0] mean_roll;
  logic tilt_alarm;
  logic led_level;
  modport source (output valid, mean_pitch, mean_roll, tilt_alarm, led_level, input ready);
  modport sink (input valid, mean_pitch, mean_roll, tilt_alarm, led_level, output ready);
endinterface
`default_nettype wire

@@ rtl/atam_angle.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atam_angle: iterative arctangent unit
// Bit-serial square root of a sum of squares, then 16 CORDIC vectoring steps.
// ----------------------------------------------------------------------------
module atam_angle
  import atam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] num,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output logic                    done,
  output logic signed [16:0]      angle
);

  aphase_t     phase, phase_next;
  logic [4:0]  cnt;
  logic [29:0] rem;       // root remainder
  logic [31:0] sq_b;
  logic [55:0] radicand;  // s << 24, shifted out two bits a step
  logic [27:0] root;
  logic signed [30:0] cx, cy;
  logic signed [24:0] cz;
  logic signed [16:0] num_q;
  logic [15:0] mag_a, mag_b;
  logic [31:0] sq_a;
  logic [31:0] rem_sh, trial, rem_diff;
  logic        root_bit;
  logic [27:0] root_next;
  logic [29:0] rem_next;
  logic signed [30:0] xs, ys;
  logic signed [24:0] zr;

  assign mag_a = a[15] ? 16'(-a) : 16'(a);
  assign mag_b = b[15] ? 16'(-b) : 16'(b);
  assign sq_a  = phase == A_IDLE ? mag_a * mag_a : mag_b * mag_b;
  assign rem_sh    = {rem, radicand[55:54]};
  assign trial     = {2'b00, root, 2'b01};
  assign rem_diff  = rem_sh - trial;
  assign root_bit  = rem_sh >= trial;
  assign rem_next  = root_bit ? rem_diff[29:0] : rem_sh[29:0];
  assign root_next = {root[26:0], root_bit};
  assign xs = cx >>> cnt[3:0];
  assign ys = cy >>> cnt[3:0];
  assign zr = (cz + 25'sd128) >>> 8;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      A_IDLE: if (start) phase_next = A_SQ;
      A_SQ:   phase_next = A_ROOT;
      A_ROOT: if (cnt == 5'd27) phase_next = A_ROT;
      A_ROT:  if (cnt == 5'd16) phase_next = A_IDLE;
      default: phase_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= A_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      unique case (phase)
        A_IDLE: if (start) begin
          sq_b  <= sq_a;
          num_q <= num;
        end
        A_SQ: begin
          radicand <= {sq_b + sq_a, 24'd0};
          rem      <= '0;
          root     <= '0;
          cnt      <= '0;
        end
        A_ROOT: begin
          rem      <= rem_next;
          root     <= root_next;
          radicand <= {radicand[53:0], 2'b00};
          if (cnt == 5'd27) begin
            // CORDIC start values: X is the root, Y is the numerator with 12 fraction bits.
            cnt <= '0;
            cx  <= {3'b000, root_next};
            cy  <= {{2{num_q[16]}}, num_q, 12'd0};
            cz  <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: begin
          if (cnt == 5'd16) begin
            if (num_q == 0) angle <= '0;
            else if (root == 0)
              angle <= num_q[16] ? -ANGLE_MAX : ANGLE_MAX;
            else if (zr > 25'(ANGLE_MAX)) angle <= ANGLE_MAX;
            else if (zr < -25'(ANGLE_MAX)) angle <= -ANGLE_MAX;
            else angle <= zr[16:0];
            done <= 1'b1;
          end else begin
            if (!cy[30]) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + 25'(atan_step(cnt[3:0]));
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - 25'(atan_step(cnt[3:0]));
            end
            cnt <= cnt + 5'd1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/accel_tilt_average_monitor_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_average_monitor_core: tilt angles with moving average and alarm
// Pitch and roll by a shared root/CORDIC unit, ring averaging, alarm and LED.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in       in   accel_x, accel_y, accel_z
//  out      out  mean_pitch, mean_roll, tilt_alarm, led_level
//  cfg      in   cfg_we, cfg_index, cfg_data
// Each sample makes two passes through the angle unit (load, 28 root steps,
// CORDIC steps, hand-off), plus accept, start, ring read, update, divide and output.
// Reset is synchronous; after it the rings are cleared before a sample is accepted.
// A waiting result blocks new samples until it is taken.
module accel_tilt_average_monitor_core
  import atam_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  atam_in_if.sink          in_ch,
  atam_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TW = ANGLE_W + AW;
  // Totals stay below 2^(16+AW) in magnitude, so this reciprocal is exact.
  localparam int unsigned RS = 16 + 2 * AW;
  localparam logic [TW-1:0] RECIP =
    TW'(((64'd1 << RS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  state_t state, state_next;
  logic signed [15:0] pitch_zero, roll_zero;
  logic [15:0] tilt_limit;
  logic signed [15:0] sx, sy, sz;
  logic second;
  logic ang_start, ang_done;
  logic signed [16:0] ang_num, ang_out;
  logic signed [15:0] ang_a, ang_b;
  logic signed [16:0] pitch, roll;
  logic signed [16:0] pitch_ring [WINDOW];
  logic signed [16:0] roll_ring [WINDOW];
  logic signed [16:0] old_p, old_r;
  logic [AW-1:0] ring_slot, clr_slot;
  logic clearing;
  logic ring_we;
  logic [AW-1:0] ring_wa;
  logic signed [16:0] ring_wp, ring_wr;
  logic signed [TW-1:0] pitch_total, roll_total;
  logic [TW-1:0] p_mag, r_mag;
  logic [2*TW-1:0] p_prod, r_prod;
  logic [16:0] p_quo, r_quo;
  logic signed [16:0] mp, mr;
  logic led_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_zero <= '0;
      roll_zero  <= '0;
      tilt_limit <= 16'd1280;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PITCH_ZERO: pitch_zero <= cfg_data;
        REG_ROLL_ZERO:  roll_zero  <= cfg_data;
        REG_TILT_LIMIT: tilt_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  atam_angle u_angle (
    .clk, .rst, .start(ang_start), .num(ang_num), .a(ang_a), .b(ang_b),
    .done(ang_done), .angle(ang_out)
  );

  assign ang_num = second ? 17'(sx) : -17'(sz);
  assign ang_a   = second ? sy : sx;
  assign ang_b   = second ? sz : sy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_ch.valid && in_ch.ready) state_next = ST_SQRT;
      ST_SQRT:    state_next = ST_CORDIC;
      ST_CORDIC:  if (ang_done) state_next = second ? ST_RING_RD : ST_NEXT;
      ST_NEXT:    state_next = ST_CORDIC;
      ST_RING_RD: state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_DIV;
      ST_DIV:     state_next = ST_OUT;
      ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == ST_IDLE) && !clearing;
    out_ch.valid = (state == ST_OUT);
    ang_start    = (state == ST_SQRT) || (state == ST_NEXT);
  end

  // Truncating divide by WINDOW: scale the magnitude by the reciprocal, then restore the sign.
  assign p_mag  = pitch_total[TW-1] ? TW'(-pitch_total) : TW'(pitch_total);
  assign r_mag  = roll_total[TW-1] ? TW'(-roll_total) : TW'(roll_total);
  assign p_prod = p_mag * RECIP;
  assign r_prod = r_mag * RECIP;
  assign p_quo  = p_prod[RS +: 17];
  assign r_quo  = r_prod[RS +: 17];

  // One write port shared by the clearing pass and the ring update.
  always_comb begin
    ring_we = clearing || (state == ST_UPDATE);
    ring_wa = clearing ? clr_slot : ring_slot;
    ring_wp = clearing ? 17'sd0 : pitch;
    ring_wr = clearing ? 17'sd0 : roll;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      pitch_ring[ring_wa] <= ring_wp;
      roll_ring[ring_wa]  <= ring_wr;
    end
    if (state == ST_RING_RD) begin
      old_p <= pitch_ring[ring_slot];
      old_r <= roll_ring[ring_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ring_slot <= '0;
      clr_slot <= '0;
      clearing <= 1'b1;
      pitch_total <= '0;
      roll_total <= '0;
      led_bit <= 1'b0;
      second <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_slot <= clr_slot + 1'b1;
        if (AW'(clr_slot) == AW'(WINDOW - 1)) clearing <= 1'b0;
      end
      if (state == ST_IDLE && in_ch.valid && in_ch.ready) begin
        sx <= in_ch.accel_x;
        sy <= in_ch.accel_y;
        sz <= in_ch.accel_z;
        second <= 1'b0;
      end
      if (state == ST_CORDIC && ang_done) begin
        if (second) roll <= ang_out - 17'(roll_zero);
        else begin
          pitch <= ang_out - 17'(pitch_zero);
          second <= 1'b1;
        end
      end
      if (state == ST_UPDATE) begin
        pitch_total <= pitch_total + TW'(pitch) - TW'(old_p);
        roll_total  <= roll_total + TW'(roll) - TW'(old_r);
        ring_slot <= (AW'(ring_slot) == AW'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
      end
      if (state == ST_DIV) begin
        mp <= pitch_total[TW-1] ? -$signed(p_quo) : $signed(p_quo);
        mr <= roll_total[TW-1] ? -$signed(r_quo) : $signed(r_quo);
      end
      if (state == ST_OUT && out_ch.ready && out_ch.tilt_alarm) led_bit <= ~led_bit;
    end
  end

  always_comb begin
    out_ch.mean_pitch = mp;
    out_ch.mean_roll  = mr;
    out_ch.tilt_alarm = ((mp[16] ? -mp : mp) > $signed({1'b0, tilt_limit}))
                     || ((mr[16] ? -mr : mr) > $signed({1'b0, tilt_limit}));
    out_ch.led_level  = led_bit ^ out_ch.tilt_alarm;
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result lost");
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ch.ready) else $error("accept during clear");
`endif

endmodule
`default_nettype wire

@@ sim/accel_tilt_average_monitor_core_tb.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_average_monitor_core_tb: self-checking bench for the tilt monitor
// Drives accelerometer samples under random idling, predicts the averaged
// pitch and roll, the alarm and the LED level, and checks every result.
// ----------------------------------------------------------------------------
module accel_tilt_average_monitor_core_tb;
  import atam_pkg::*;

  localparam int WIN = 64;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] pitch;
    logic signed [16:0] roll;
    logic alarm;
    logic led;
  } tilt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PITCH_ZERO;
  logic [15:0] cfg_data = '0;

  atam_in_if in_ch();
  atam_out_if out_ch();

  accel_tilt_average_monitor_core #(.WINDOW(WIN)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  int pitch_hist[WIN];
  int roll_hist[WIN];
  int hist_slot;
  int pitch_sum;
  int roll_sum;
  bit led_state;
  int pitch_trim;
  int roll_trim;
  int alarm_limit;

  sample_t pending_samples[$];
  tilt_result_t expected_results[$];
  int send_idle_pct = 26;
  int recv_idle_pct = 60;
  int errors = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic int tilt_of(int num, int a, int b);
    longint unsigned s;
    longint mag;
    longint cx;
    longint cy;
    longint cz;
    longint xs;
    longint ys;
    longint r;
    s = longint'(a) * a + longint'(b) * b;
    mag = root64(s << 24);
    if (num == 0) return 0;
    if (mag == 0) return num > 0 ? 11520 : -11520;
    cx = mag;
    cy = longint'(num) * 4096;
    cz = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shift(cx, i);
      ys = floor_shift(cy, i);
      if (cy >= 0) begin
        cx += ys; cy -= xs; cz += longint'(atan_step(4'(i)));
      end else begin
        cx -= ys; cy += xs; cz -= longint'(atan_step(4'(i)));
      end
    end
    r = floor_shift(cz + 128, 8);
    if (r > 11520) r = 11520;
    if (r < -11520) r = -11520;
    return int'(r);
  endfunction

  function automatic tilt_result_t average_tilt(sample_t smp);
    tilt_result_t res;
    int p;
    int q;
    int mp;
    int mr;
    int ap;
    int ar;
    p = tilt_of(-int'(smp.z), smp.x, smp.y) - pitch_trim;
    q = tilt_of(int'(smp.x), smp.y, smp.z) - roll_trim;
    pitch_sum += p - pitch_hist[hist_slot];
    roll_sum += q - roll_hist[hist_slot];
    pitch_hist[hist_slot] = p;
    roll_hist[hist_slot] = q;
    hist_slot = (hist_slot + 1) % WIN;
    mp = pitch_sum / WIN;
    mr = roll_sum / WIN;
    ap = mp < 0 ? -mp : mp;
    ar = mr < 0 ? -mr : mr;
    res.alarm = (ap > alarm_limit) || (ar > alarm_limit);
    if (res.alarm) led_state = ~led_state;
    res.pitch = 17'(mp);
    res.roll = 17'(mr);
    res.led = led_state;
    return res;
  endfunction

  // Driver: one request from the queue at a time, random gaps between them.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // Hold the request.
    end else begin
      if (in_ch.valid) expected_results.push_back(average_tilt(
          {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z}));
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.accel_x <= s.x;
        in_ch.accel_y <= s.y;
        in_ch.accel_z <= s.z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and random stall of the result side.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result pitch=%0d roll=%0d", $time,
                   out_ch.mean_pitch, out_ch.mean_roll);
          errors++;
        end else begin
          tilt_result_t e;
          e = expected_results.pop_front();
          if (out_ch.mean_pitch !== e.pitch) begin
            $display("%0t: mean_pitch expected %0d actual %0d", $time, e.pitch,
                     out_ch.mean_pitch);
            errors++;
          end
          if (out_ch.mean_roll !== e.roll) begin
            $display("%0t: mean_roll expected %0d actual %0d", $time, e.roll,
                     out_ch.mean_roll);
            errors++;
          end
          if (out_ch.tilt_alarm !== e.alarm) begin
            $display("%0t: tilt_alarm expected %0b actual %0b", $time, e.alarm,
                     out_ch.tilt_alarm);
            errors++;
          end
          if (out_ch.led_level !== e.led) begin
            $display("%0t: led_level expected %0b actual %0b", $time, e.led,
                     out_ch.led_level);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(3));
      1: return 16'(16'h7fff - $urandom_range(3));
      2: return 16'($urandom_range(8) - 4);
      3: return 16'($urandom_range(600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample(int tilted);
    sample_t s;
    s.x = rand_axis();
    s.y = rand_axis();
    s.z = rand_axis();
    // Steady tilt so the averages climb past the limit.
    if (tilted != 0) begin
      s.x = 16'(12000 + $urandom_range(4000));
      s.z = 16'(-int'($urandom_range(8000)));
    end
    return s;
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PITCH_ZERO: pitch_trim = int'(signed'(val));
      REG_ROLL_ZERO: roll_trim = int'(signed'(val));
      REG_TILT_LIMIT: alarm_limit = int'(val);
      default: ;
    endcase
  endtask

  task automatic run_random(int n, int tilt_pct);
    for (int i = 0; i < n; i++)
      pending_samples.push_back(rand_sample($urandom_range(99) < tilt_pct));
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) begin
      pitch_hist[i] = 0;
      roll_hist[i] = 0;
    end
    hist_slot = 0; pitch_sum = 0; roll_sum = 0; led_state = 0;
    pitch_trim = 0; roll_trim = 0; alarm_limit = 1280;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The rings clear after reset before the first sample is taken.
    repeat (WIN + 10) @(posedge clk);

    // Directed: zero sample, axis extremes, zero magnitude cases.
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'sh7fff, 16'sd0, 16'sd0});
    pending_samples.push_back('{-16'sh8000, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'sd0, 16'sd0, 16'sh7fff});
    pending_samples.push_back('{16'sd0, 16'sd0, -16'sh8000});
    pending_samples.push_back('{16'sd0, 16'sh7fff, 16'sd0});
    pending_samples.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
    pending_samples.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_samples.push_back('{16'sd1, 16'sd0, 16'sd0});
    pending_samples.push_back('{16'sd0, -16'sd1, 16'sd1});
    pending_samples.push_back('{16'sh5555, -16'sh2aab, 16'sh1234});
    for (int i = 0; i < 10; i++) pending_samples.push_back('{16'sd16000, 16'sd0, 16'sd0});
    run_random(300, 40);
    drain();

    // Sender waits for the result side to empty, with extreme settings.
    write_reg(REG_PITCH_ZERO, 16'(-23040));
    write_reg(REG_ROLL_ZERO, 16'd23040);
    write_reg(REG_TILT_LIMIT, 16'd0);
    write_reg(2'd3, 16'hffff);
    run_random(300, 30);
    drain();

    send_idle_pct = 60;
    recv_idle_pct = 26;
    write_reg(REG_PITCH_ZERO, 16'h8000);
    write_reg(REG_ROLL_ZERO, 16'h7fff);
    write_reg(REG_TILT_LIMIT, 16'd46080);
    run_random(300, 50);
    drain();
    write_reg(REG_TILT_LIMIT, 16'hffff);
    write_reg(REG_PITCH_ZERO, 16'd100);
    write_reg(REG_ROLL_ZERO, 16'(-100));
    run_random(250, 20);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_TILT_LIMIT, 16'd640);
    write_reg(REG_PITCH_ZERO, 16'd0);
    write_reg(REG_ROLL_ZERO, 16'd0);
    run_random(630, 50);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ accel_tilt_average_monitor_core.f @@
rtl/atam_pkg.sv
rtl/atam_if.sv
rtl/atam_angle.sv
rtl/accel_tilt_average_monitor_core.sv
sim/accel_tilt_average_monitor_core_tb.sv
